/* rtl/brf_pkg.sv */
// types and codes shared by the byte ring fifo top level and its pointer control
// no dependencies
package brf_pkg;

  typedef enum logic [2:0] {
    OP_WRITE     = 3'd0,
    OP_READ      = 3'd1,
    OP_PEEK      = 3'd2,
    OP_REMOVE    = 3'd3,
    OP_AVAILABLE = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  localparam int unsigned FillW = 12;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data_in;
    logic [7:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       data_out;
    logic [1:0]       status;
    logic [FillW-1:0] fill_count;
  } out_item_t;

  // outcome of one operation, handed from pointer control to the top level
  typedef struct packed {
    logic             mem_we;
    logic             data_vld;
    status_e          status;
    logic [FillW-1:0] fill_count;
  } ctrl_res_t;

endpackage

/* rtl/brf_ptr_ctrl.sv */
// read and write pointer registers and per-operation decode for the byte ring fifo
// depends on brf_pkg
module brf_ptr_ctrl #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  brf_pkg::in_item_t            op_i,
  output logic [$clog2(DEPTH)-1:0]     wr_addr_o,
  output logic [$clog2(DEPTH)-1:0]     rd_addr_o,
  output brf_pkg::ctrl_res_t           res_o
);
  import brf_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW:0]   DepthW = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  logic [AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [AW-1:0] wp_inc, rp_inc, peek_addr;
  logic [AW:0]   peek_sum, fill_diff, fill;
  logic          empty, full;
  logic [AW-1:0] amt_mod_tbl [256];

  // amount reduced modulo depth, built at elaboration
  for (genvar g = 0; g < 256; g++) begin : g_amt_mod
    localparam int unsigned ModVal = g % DEPTH;
    assign amt_mod_tbl[g] = AW'(ModVal);
  end

  assign empty  = (wp_q == rp_q);
  assign wp_inc = (wp_q == LastIdx) ? '0 : wp_q + AW'(1);
  assign rp_inc = (rp_q == LastIdx) ? '0 : rp_q + AW'(1);
  assign full   = (wp_inc == rp_q);

  assign peek_sum  = {1'b0, rp_q} + {1'b0, amt_mod_tbl[op_i.amount]};
  assign peek_addr = (peek_sum >= DepthW) ? AW'(peek_sum - DepthW) : AW'(peek_sum);

  assign wr_addr_o = wp_q;
  assign rd_addr_o = (op_i.opcode == OP_READ) ? rp_q : peek_addr;

  always_comb begin
    wp_d           = wp_q;
    rp_d           = rp_q;
    res_o.mem_we   = 1'b0;
    res_o.data_vld = 1'b0;
    res_o.status   = ST_OK;
    unique case (op_i.opcode)
      OP_WRITE: begin
        if (full) begin
          res_o.status = ST_FULL;
        end else begin
          res_o.mem_we = 1'b1;
          wp_d         = wp_inc;
        end
      end
      OP_READ: begin
        if (empty) begin
          res_o.status = ST_EMPTY;
        end else begin
          res_o.data_vld = 1'b1;
          // draining the last byte returns both pointers home
          if (rp_inc == wp_q) begin
            rp_d = '0;
            wp_d = '0;
          end else begin
            rp_d = rp_inc;
          end
        end
      end
      OP_PEEK: begin
        if (empty) begin
          res_o.status = ST_EMPTY;
        end else begin
          res_o.data_vld = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          res_o.status = ST_EMPTY;
        end else begin
          rp_d = peek_addr;
        end
      end
      default: begin
      end
    endcase
    fill_diff = {1'b0, wp_d} - {1'b0, rp_d};
    fill      = fill_diff[AW] ? fill_diff + DepthW : fill_diff;
    res_o.fill_count = FillW'(fill);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else if (go_i) begin
      wp_q <= wp_d;
      rp_q <= rp_d;
    end
  end

endmodule

/* rtl/byte_ring_fifo_with_peek.sv */
// top level of the byte ring fifo with peek: storage memory, clear sweep, result pipeline
// depends on brf_pkg and brf_ptr_ctrl
//
// usage:
//   input channel  in_valid_i / in_stall_o / in_data_i carries one operation
//   (write, read, peek, remove, available) per transaction
//   output channel out_valid_o / out_stall_i / out_data_o returns exactly one
//   result per operation, in order: byte, status and fill count after the op
// pipeline: an accepted operation passes the read stage, then the output register
// the storage memory read is registered, and the next operation is taken only
//   once the previous result has left the read stage
// reset: pointers clear at once, then the storage is swept to zero, one
//   entry a cycle, through all DEPTH entries; in_stall_o stays high during the sweep
// stall: while out_stall_i holds a pending result, out_data_o stays put and
//   in_stall_o is raised, so no operation is lost or reordered
module byte_ring_fifo_with_peek #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  brf_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output brf_pkg::out_item_t out_data_o
);
  import brf_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    mem_rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  logic          clr_q;
  logic [AW-1:0] clr_addr_q;

  logic          accept;
  logic [AW-1:0] wr_addr, rd_addr;
  ctrl_res_t     res;

  logic          s1_vld_q;
  ctrl_res_t     s1_res_q;
  logic          out_vld_q;
  out_item_t     out_q;

  brf_ptr_ctrl #(
    .DEPTH(DEPTH)
  ) u_ptr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (accept),
    .op_i      (in_data_i),
    .wr_addr_o (wr_addr),
    .rd_addr_o (rd_addr),
    .res_o     (res)
  );

  assign in_stall_o = clr_q || s1_vld_q || (out_vld_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign mem_we    = clr_q || (accept && res.mem_we);
  assign mem_waddr = clr_q ? clr_addr_q : wr_addr;
  assign mem_wdata = clr_q ? 8'd0 : in_data_i.data_in;

  // zero sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == LastIdx) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      mem_rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      if (s1_vld_q) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res;
    end
    if (s1_vld_q) begin
      out_q.data_out   <= s1_res_q.data_vld ? mem_rdata_q : 8'd0;
      out_q.status     <= s1_res_q.status;
      out_q.fill_count <= s1_res_q.fill_count;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // the output register is always free when the read stage hands over
  a_s1_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> !out_vld_q)
    else $error("read stage result would overwrite a pending output");

  a_accept_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_vld_q && !$past(clr_q))
    else $error("accepted transaction did not reach the read stage");

  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_q.status != ST_OK) |-> (out_q.data_out == 8'd0))
    else $error("failed operation returned nonzero data");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ({1'b0, out_q.fill_count} < 13'(DEPTH)))
    else $error("fill count out of range");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s1_vld_q && !out_vld_q)
    else $error("result pending during storage clear");
`endif

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// testbench for byte_ring_fifo_with_peek: directed and random operations checked
// in order against a ring model kept by a small scoreboard class
// depends on brf_pkg and the byte_ring_fifo_with_peek rtl
module tb_top;
  import brf_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam logic [2:0] OpSpareLo = 3'd5;
  localparam logic [2:0] OpSpareHi = 3'd7;
  localparam int unsigned RandomOps = 550;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles = 150;

  class ring_scoreboard;
    logic [7:0]      cells [DEPTH];
    logic [PtrW-1:0] wr_ptr;
    logic [PtrW-1:0] rd_ptr;
    out_item_t       expected_q [$];
    int unsigned     errors;
    int unsigned     checked;
    int unsigned     full_hits;
    int unsigned     empty_hits;
    int unsigned     op_seen [8];

    function new();
      foreach (cells[i]) cells[i] = '0;
      wr_ptr = '0;
      rd_ptr = '0;
      errors = 0;
      checked = 0;
      full_hits = 0;
      empty_hits = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    // work out the result of one accepted operation and queue it
    function void note_op(in_item_t op);
      out_item_t res;
      logic      is_empty;
      res = '0;
      res.status = ST_OK;
      is_empty = (wr_ptr == rd_ptr);
      op_seen[op.opcode]++;
      case (op.opcode)
        OP_WRITE: begin
          if (PtrW'((wr_ptr + 1) % DEPTH) == rd_ptr) begin
            res.status = ST_FULL;
          end else begin
            cells[wr_ptr] = op.data_in;
            wr_ptr = PtrW'((wr_ptr + 1) % DEPTH);
          end
        end
        OP_READ: begin
          if (is_empty) begin
            res.status = ST_EMPTY;
          end else begin
            res.data_out = cells[rd_ptr];
            rd_ptr = PtrW'((rd_ptr + 1) % DEPTH);
            // draining the last byte rewinds both pointers
            if (rd_ptr == wr_ptr) begin
              rd_ptr = '0;
              wr_ptr = '0;
            end
          end
        end
        OP_PEEK: begin
          if (is_empty) res.status = ST_EMPTY;
          else res.data_out = cells[PtrW'((rd_ptr + op.amount) % DEPTH)];
        end
        OP_REMOVE: begin
          // no bound check against the count, and no rewind
          if (is_empty) res.status = ST_EMPTY;
          else rd_ptr = PtrW'((rd_ptr + op.amount) % DEPTH);
        end
        default: begin
        end
      endcase
      res.fill_count = FillW'((DEPTH + wr_ptr - rd_ptr) % DEPTH);
      expected_q.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $error("result with no operation pending: data_out %0d status %0d fill_count %0d",
               got.data_out, got.status, got.fill_count);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.status == ST_FULL) full_hits++;
      if (want.status == ST_EMPTY) empty_hits++;
      if (got.data_out !== want.data_out) begin
        errors++;
        $error("data_out: expected %0d, actual %0d", want.data_out, got.data_out);
      end
      if (got.status !== want.status) begin
        errors++;
        $error("status: expected %0d, actual %0d", want.status, got.status);
      end
      if (got.fill_count !== want.fill_count) begin
        errors++;
        $error("fill_count: expected %0d, actual %0d", want.fill_count, got.fill_count);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;

  int unsigned src_idle_pct;
  int unsigned dst_stall_pct;
  logic        hold_req;
  int unsigned cycle_cnt;

  ring_scoreboard sb;

  byte_ring_fifo_with_peek #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("status: fail");
    $finish;
  end

  // receiver: random stall, or a long hold-off counted here
  initial begin : p_receiver
    int unsigned hold_cnt;
    out_stall = 1'b0;
    hold_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_req && (hold_cnt < HoldCycles)) begin
        out_stall <= 1'b1;
        hold_cnt++;
      end else begin
        out_stall <= ($urandom_range(99) < dst_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_op(in_data);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // offer one transaction, with random idle cycles ahead of it
  task automatic send_op(input in_item_t op);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic in_item_t make_op(logic [2:0] code, logic [7:0] din, logic [7:0] amt);
    in_item_t op;
    op.opcode  = code;
    op.data_in = din;
    op.amount  = amt;
    return op;
  endfunction

  function automatic in_item_t pick_op(int unsigned write_pct);
    in_item_t    op;
    int unsigned r;
    op.data_in = 8'($urandom);
    op.amount  = 8'($urandom);
    if ($urandom_range(99) < write_pct) begin
      op.opcode = OP_WRITE;
    end else begin
      r = $urandom_range(99);
      if (r < 40) begin
        op.opcode = OP_READ;
      end else if (r < 65) begin
        op.opcode = OP_PEEK;
      end else if (r < 80) begin
        op.opcode = OP_REMOVE;
        // mostly short discards so the ring can still fill up
        if ($urandom_range(3) != 0) op.amount = 8'($urandom_range(4));
      end else if (r < 93) begin
        op.opcode = OP_AVAILABLE;
      end else begin
        op.opcode = 3'($urandom_range(OpSpareHi, OpSpareLo));
      end
    end
    return op;
  endfunction

  initial begin
    in_item_t    directed [$];
    int unsigned sent;
    int unsigned burst_len;
    int unsigned write_pct;
    int unsigned phase;

    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    src_idle_pct = 0;
    dst_stall_pct = 0;
    hold_req = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // corner cases on an empty ring, extremes of data and offset,
    // over-count discard, rewind on drain, undefined opcodes
    directed = '{
      make_op(OP_AVAILABLE, 8'h00, 8'h00),
      make_op(OP_READ,      8'hff, 8'hff),
      make_op(OP_PEEK,      8'h00, 8'h00),
      make_op(OP_REMOVE,    8'h00, 8'hff),
      make_op(OP_WRITE,     8'h00, 8'h00),
      make_op(OP_WRITE,     8'hff, 8'hff),
      make_op(OP_WRITE,     8'ha5, 8'h00),
      make_op(OP_PEEK,      8'h00, 8'h00),
      make_op(OP_PEEK,      8'h00, 8'hff),
      make_op(OP_PEEK,      8'h00, 8'h02),
      make_op(OP_READ,      8'h00, 8'h00),
      make_op(OP_REMOVE,    8'h00, 8'hff),
      make_op(OP_AVAILABLE, 8'hff, 8'hff),
      make_op(OP_READ,      8'h00, 8'h00),
      make_op(OP_READ,      8'h00, 8'h00),
      make_op(OP_READ,      8'h00, 8'h00),
      make_op(OpSpareHi,    8'h00, 8'h00),
      make_op(OpSpareLo,    8'hff, 8'hff),
      make_op(OP_WRITE,     8'h5a, 8'h00),
      make_op(OP_REMOVE,    8'h00, 8'h01),
      make_op(OP_WRITE,     8'h3c, 8'h00),
      make_op(OP_READ,      8'h00, 8'h00)
    };
    foreach (directed[i]) send_op(directed[i]);

    // hold the receiver off while the sender keeps pushing
    hold_req = 1'b1;

    sent = 0;
    while (sent < RandomOps) begin
      phase = sent * 4 / RandomOps;
      case (phase)
        0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
        1: begin src_idle_pct = 83; dst_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  dst_stall_pct = 83; end
        default: begin src_idle_pct = 19; dst_stall_pct = 19; end
      endcase
      // the first burst is write heavy and long enough to reach full
      if (sent == 0) begin
        write_pct = 95;
        burst_len = 80;
      end else begin
        case ($urandom_range(3))
          0: write_pct = 90;
          1: write_pct = 70;
          2: write_pct = 50;
          default: write_pct = 20;
        endcase
        burst_len = $urandom_range(60, 20);
      end
      if (burst_len > RandomOps - sent) burst_len = RandomOps - sent;
      repeat (burst_len) begin
        send_op(pick_op(write_pct));
        sent++;
      end
    end

    dst_stall_pct = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("checked %0d results: %0d writes, %0d reads, %0d peeks, %0d removes, %0d counts",
             sb.checked, sb.op_seen[OP_WRITE], sb.op_seen[OP_READ], sb.op_seen[OP_PEEK],
             sb.op_seen[OP_REMOVE], sb.op_seen[OP_AVAILABLE]);
    $display("full status seen %0d times, empty status %0d times, %0d mismatches",
             sb.full_hits, sb.empty_hits, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
